/* design/amst_pkg.sv */
// shared constants, types and tables for the affine matrix stack engine
package amst_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int FRAC_BITS = 16;
  localparam int MAT_WORDS = 12;
  localparam int LVL_W = $clog2(STACK_DEPTH);
  localparam int IDX_W = $clog2(MAT_WORDS);
  localparam int ADDR_W = $clog2(STACK_DEPTH * MAT_WORDS);

  // cordic
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int ANG_FRAC = 24;
  localparam int VEC_FRAC = 30;
  localparam int ANG_W = 36;
  localparam int VEC_W = 34;
  localparam int CORDIC_GAIN = 652032874;
  localparam int RED_K = (FRAC_BITS >= 23) ? 0 : 23 - FRAC_BITS;
  localparam int RED_KW = 4;
  localparam int RED_W = FRAC_BITS + 9 + RED_K + 1;

  localparam logic [3:0] OP_IDENT = 4'd0;
  localparam logic [3:0] OP_PUSH  = 4'd1;
  localparam logic [3:0] OP_POP   = 4'd2;
  localparam logic [3:0] OP_ROTX  = 4'd3;
  localparam logic [3:0] OP_ROTY  = 4'd4;
  localparam logic [3:0] OP_ROTZ  = 4'd5;
  localparam logic [3:0] OP_TRANS = 4'd6;
  localparam logic [3:0] OP_SCALE = 4'd7;
  localparam logic [3:0] OP_POINT = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] WR_IDENT = 2'd0;
  localparam logic [1:0] WR_COPY  = 2'd1;
  localparam logic [1:0] WR_SUM   = 2'd2;

  localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

  typedef struct packed {
    logic              cap;
    logic              cord_start;
    logic              rd_en;
    logic [LVL_W-1:0]  rd_lvl;
    logic [IDX_W-1:0]  rd_idx;
    logic              row_ld;
    logic [1:0]        row_k;
    logic              mul_en;
    logic [1:0]        col;
    logic              wr_en;
    logic [1:0]        wr_src;
    logic [LVL_W-1:0]  wr_lvl;
    logic [IDX_W-1:0]  wr_idx;
    logic              pt_ld;
    logic [1:0]        pt_row;
    logic              out_ld;
    logic [1:0]        status;
  } amst_cmd_t;

  typedef struct packed {
    logic cord_done;
  } amst_sts_t;

  function automatic logic signed [31:0] ident_word(input logic [IDX_W-1:0] idx);
    logic signed [31:0] w;
    w = '0;
    if (idx == IDX_W'(0) || idx == IDX_W'(5) || idx == IDX_W'(10)) w = Q_ONE;
    return w;
  endfunction

  function automatic logic [29:0] atan_deg(input logic [STEP_W-1:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'd754974720;
      5'd1:  a = 30'd445687602;
      5'd2:  a = 30'd235489089;
      5'd3:  a = 30'd119537938;
      5'd4:  a = 30'd60000934;
      5'd5:  a = 30'd30029717;
      5'd6:  a = 30'd15018523;
      5'd7:  a = 30'd7509720;
      5'd8:  a = 30'd3754917;
      5'd9:  a = 30'd1877466;
      5'd10: a = 30'd938734;
      5'd11: a = 30'd469367;
      5'd12: a = 30'd234684;
      5'd13: a = 30'd117342;
      5'd14: a = 30'd58671;
      5'd15: a = 30'd29335;
      5'd16: a = 30'd14668;
      5'd17: a = 30'd7334;
      5'd18: a = 30'd3667;
      5'd19: a = 30'd1833;
      5'd20: a = 30'd917;
      5'd21: a = 30'd458;
      5'd22: a = 30'd229;
      5'd23: a = 30'd115;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* design/amst_cordic.sv */
// iterative angle reduction and cordic sine/cosine unit
module amst_cordic (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  angle,
  output logic                done,
  output logic signed [31:0]  sn,
  output logic signed [31:0]  cs
);
  import amst_pkg::*;

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_RED  = 3'd1;
  localparam logic [2:0] C_SET  = 3'd2;
  localparam logic [2:0] C_ROT  = 3'd3;
  localparam logic [2:0] C_FIN  = 3'd4;

  localparam logic [RED_W-1:0] FULL = RED_W'(360) << FRAC_BITS;
  localparam logic [RED_W-1:0] OFFSET = FULL << RED_K;
  localparam logic signed [ANG_W-1:0] A90  = ANG_W'(90) <<< ANG_FRAC;
  localparam logic signed [ANG_W-1:0] A180 = ANG_W'(180) <<< ANG_FRAC;
  localparam logic signed [ANG_W-1:0] A270 = ANG_W'(270) <<< ANG_FRAC;
  localparam logic signed [ANG_W-1:0] A360 = ANG_W'(360) <<< ANG_FRAC;
  localparam int VSH = VEC_FRAC - FRAC_BITS;
  localparam logic signed [VEC_W-1:0] HALF = VEC_W'(1) <<< (VSH - 1);

  logic [2:0]                state;
  logic [RED_KW-1:0]         k;
  logic [RED_W-1:0]          r;
  logic [STEP_W-1:0]         i;
  logic signed [ANG_W-1:0]   t;
  logic signed [VEC_W-1:0]   x;
  logic signed [VEC_W-1:0]   y;
  logic                      flip;

  logic [RED_W-1:0]          sub;
  logic signed [ANG_W-1:0]   ra;
  logic signed [ANG_W-1:0]   at;
  logic signed [VEC_W-1:0]   xs;
  logic signed [VEC_W-1:0]   ys;
  logic signed [VEC_W-1:0]   xr;
  logic signed [VEC_W-1:0]   yr;

  assign sub = FULL << k;
  assign ra  = ANG_W'(r) <<< (ANG_FRAC - FRAC_BITS);
  assign at  = ANG_W'(atan_deg(i));
  assign xs  = x >>> i;
  assign ys  = y >>> i;
  assign xr  = (x + HALF) >>> VSH;
  assign yr  = (y + HALF) >>> VSH;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == C_FIN);
      unique case (state)
        C_IDLE: if (start) state <= C_RED;
        C_RED:  if (k == '0) state <= C_SET;
        C_SET:  state <= C_ROT;
        C_ROT:  if (i == STEP_W'(CORDIC_STEPS - 1)) state <= C_FIN;
        C_FIN:  state <= C_IDLE;
        default: state <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        r <= RED_W'(angle) + (angle[31] ? OFFSET : '0);
        k <= RED_KW'(RED_K);
      end
      C_RED: begin
        if (r >= sub) r <= r - sub;
        k <= k - 1'b1;
      end
      C_SET: begin
        x <= VEC_W'(CORDIC_GAIN);
        y <= '0;
        i <= '0;
        if (ra > A270) begin
          t    <= ra - A360;
          flip <= 1'b0;
        end else if (ra > A90) begin
          t    <= ra - A180;
          flip <= 1'b1;
        end else begin
          t    <= ra;
          flip <= 1'b0;
        end
      end
      C_ROT: begin
        if (!t[ANG_W-1]) begin
          x <= x - ys;
          y <= y + xs;
          t <= t - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          t <= t + at;
        end
        i <= i + 1'b1;
      end
      C_FIN: begin
        cs <= flip ? -xr[31:0] : xr[31:0];
        sn <= flip ? -yr[31:0] : yr[31:0];
      end
      default: ;
    endcase
  end

endmodule

/* design/amst_dp.sv */
// datapath: matrix memory, row buffer, multipliers, sum and output registers
module amst_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  amst_pkg::amst_cmd_t    cmd,
  output amst_pkg::amst_sts_t    sts,
  input  logic [3:0]             op,
  input  logic signed [31:0]     angle_deg,
  input  logic signed [31:0]     x_in,
  input  logic signed [31:0]     y_in,
  input  logic signed [31:0]     z_in,
  output logic signed [31:0]     x_out,
  output logic signed [31:0]     y_out,
  output logic signed [31:0]     z_out,
  output logic [1:0]             status
);
  import amst_pkg::*;

  localparam int SUM_W = 51;
  localparam logic signed [SUM_W-1:0] MAXV = SUM_W'(32'sh7fffffff);
  localparam logic signed [SUM_W-1:0] MINV = -SUM_W'(64'sh80000000);
  localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

  function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] lvl,
                                                input logic [IDX_W-1:0] idx);
    return ADDR_W'(lvl) * ADDR_W'(MAT_WORDS) + ADDR_W'(idx);
  endfunction

  function automatic logic signed [SUM_W-1:0] qrnd(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = (p + RND) >>> FRAC_BITS;
    return SUM_W'(s);
  endfunction

  logic [3:0]                op_q;
  logic signed [31:0]        x_q, y_q, z_q;
  logic signed [31:0]        sn, cs, nsn;
  logic                      cord_done;

  logic signed [31:0]        mem [STACK_DEPTH*MAT_WORDS];
  logic signed [31:0]        mem_q;
  logic                      rd_fix;
  logic signed [31:0]        rd_idw;
  logic [MAT_WORDS-1:0]      lvl0_ok;
  logic signed [31:0]        rdata;

  logic signed [31:0]        row [4];
  logic signed [31:0]        tm [MAT_WORDS];
  logic signed [63:0]        p0, p1, p2;
  logic [1:0]                col_q;
  logic signed [SUM_W-1:0]   acc;
  logic signed [31:0]        sat;
  logic signed [31:0]        wdata;
  logic signed [31:0]        px, py, pz;

  amst_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.cord_start),
    .angle (angle_deg),
    .done  (cord_done),
    .sn    (sn),
    .cs    (cs)
  );

  assign sts.cord_done = cord_done;
  assign nsn = -sn;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_q <= op;
      x_q  <= x_in;
      y_q  <= y_in;
      z_q  <= z_in;
    end
  end

  // level zero reads as identity until each word is written
  always_ff @(posedge clk) begin
    if (rst) begin
      lvl0_ok <= '0;
    end else if (cmd.wr_en && cmd.wr_lvl == '0) begin
      lvl0_ok[cmd.wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[addr_of(cmd.wr_lvl, cmd.wr_idx)] <= wdata;
    if (cmd.rd_en) begin
      mem_q  <= mem[addr_of(cmd.rd_lvl, cmd.rd_idx)];
      rd_fix <= (cmd.rd_lvl == '0) && !lvl0_ok[cmd.rd_idx];
      rd_idw <= ident_word(cmd.rd_idx);
    end
  end

  assign rdata = rd_fix ? rd_idw : mem_q;

  always_ff @(posedge clk) begin
    if (cmd.row_ld) row[cmd.row_k] <= rdata;
  end

  // elementary matrix for the current command
  always_comb begin
    for (int e = 0; e < MAT_WORDS; e++) tm[e] = ident_word(IDX_W'(e));
    case (op_q) inside
      OP_ROTX: begin
        tm[5] = cs; tm[6] = nsn; tm[9] = sn; tm[10] = cs;
      end
      OP_ROTY: begin
        tm[0] = cs; tm[2] = sn; tm[8] = nsn; tm[10] = cs;
      end
      OP_ROTZ: begin
        tm[0] = cs; tm[1] = nsn; tm[4] = sn; tm[5] = cs;
      end
      OP_TRANS, OP_POINT: begin
        tm[3] = x_q; tm[7] = y_q; tm[11] = z_q;
      end
      OP_SCALE: begin
        tm[0] = x_q; tm[5] = y_q; tm[10] = z_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p0    <= 64'(row[0]) * 64'(tm[IDX_W'(cmd.col)]);
      p1    <= 64'(row[1]) * 64'(tm[IDX_W'(cmd.col) + IDX_W'(4)]);
      p2    <= 64'(row[2]) * 64'(tm[IDX_W'(cmd.col) + IDX_W'(8)]);
      col_q <= cmd.col;
    end
  end

  assign acc = qrnd(p0) + qrnd(p1) + qrnd(p2)
             + ((col_q == 2'd3) ? SUM_W'(row[3]) : '0);

  always_comb begin
    if (acc > MAXV)      sat = 32'sh7fffffff;
    else if (acc < MINV) sat = 32'sh80000000;
    else                 sat = acc[31:0];
  end

  always_comb begin
    case (cmd.wr_src)
      WR_IDENT: wdata = ident_word(cmd.wr_idx);
      WR_COPY:  wdata = rdata;
      default:  wdata = sat;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.pt_ld) begin
      case (cmd.pt_row)
        2'd0:    px <= sat;
        2'd1:    py <= sat;
        default: pz <= sat;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      x_out  <= (op_q == OP_POINT) ? px : '0;
      y_out  <= (op_q == OP_POINT) ? py : '0;
      z_out  <= (op_q == OP_POINT) ? pz : '0;
      status <= cmd.status;
    end
  end

endmodule

/* design/amst_ctrl.sv */
// controller: command decode, stack level and memory sequencing
module amst_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [3:0]             op,
  output logic                   out_valid,
  input  logic                   out_stall,
  output amst_pkg::amst_cmd_t    cmd,
  input  amst_pkg::amst_sts_t    sts
);
  import amst_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WRID = 3'd1;
  localparam logic [2:0] S_COPY = 3'd2;
  localparam logic [2:0] S_CORD = 3'd3;
  localparam logic [2:0] S_MAT  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [3:0] PH_RD_END = 4'd4;
  localparam logic [3:0] PH_ROW    = 4'd1;
  localparam logic [3:0] PH_MUL    = 4'd5;
  localparam logic [3:0] PH_WR     = 4'd6;
  localparam logic [3:0] PH_LAST   = 4'd9;
  localparam logic [3:0] CNT_LAST  = 4'(MAT_WORDS - 1);
  localparam logic [3:0] CNT_COPY  = 4'(MAT_WORDS);
  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(STACK_DEPTH - 1);

  logic [2:0]        state, state_next;
  logic [3:0]        op_q;
  logic [LVL_W-1:0]  top, top_next;
  logic [3:0]        cnt, cnt_next;
  logic [1:0]        row, row_next;
  logic [3:0]        ph, ph_next;
  logic [1:0]        stat, stat_next;
  logic              accept;
  logic              out_free;
  logic              point;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign point    = (op_q == OP_POINT);

  always_comb begin
    state_next = state;
    top_next   = top;
    cnt_next   = cnt;
    row_next   = row;
    ph_next    = ph;
    stat_next  = stat;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.cap = accept;
        if (accept) begin
          stat_next = ST_OK;
          cnt_next  = '0;
          row_next  = '0;
          ph_next   = '0;
          unique case (op) inside
            OP_IDENT: state_next = S_WRID;
            OP_PUSH: begin
              if (top == LVL_TOP) begin
                stat_next  = ST_FULL;
                state_next = S_FIN;
              end else begin
                state_next = S_COPY;
              end
            end
            OP_POP: begin
              if (top == '0) stat_next = ST_EMPTY;
              else top_next = top - 1'b1;
              state_next = S_FIN;
            end
            OP_ROTX, OP_ROTY, OP_ROTZ: begin
              cmd.cord_start = 1'b1;
              state_next     = S_CORD;
            end
            OP_TRANS, OP_SCALE, OP_POINT: state_next = S_MAT;
            default: state_next = S_FIN;
          endcase
        end
      end
      S_WRID: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_IDENT;
        cmd.wr_lvl = top;
        cmd.wr_idx = cnt;
        cnt_next   = cnt + 1'b1;
        if (cnt == CNT_LAST) state_next = S_FIN;
      end
      S_COPY: begin
        cmd.rd_en  = (cnt < CNT_COPY);
        cmd.rd_lvl = top;
        cmd.rd_idx = cnt;
        cmd.wr_en  = (cnt != '0);
        cmd.wr_src = WR_COPY;
        cmd.wr_lvl = top + 1'b1;
        cmd.wr_idx = cnt - 1'b1;
        cnt_next   = cnt + 1'b1;
        if (cnt == CNT_COPY) begin
          top_next   = top + 1'b1;
          state_next = S_FIN;
        end
      end
      S_CORD: begin
        if (sts.cord_done) state_next = S_MAT;
      end
      S_MAT: begin
        cmd.rd_en  = (ph < PH_RD_END);
        cmd.rd_lvl = top;
        cmd.rd_idx = {row, ph[1:0]};
        cmd.row_ld = (ph >= PH_ROW) && (ph < PH_MUL);
        cmd.row_k  = 2'(ph - PH_ROW);
        cmd.mul_en = (ph >= PH_MUL) && (ph < PH_LAST);
        cmd.col    = 2'(ph - PH_MUL);
        cmd.wr_en  = !point && (ph >= PH_WR);
        cmd.wr_src = WR_SUM;
        cmd.wr_lvl = top;
        cmd.wr_idx = {row, 2'(ph - PH_WR)};
        cmd.pt_ld  = point && (ph == PH_LAST);
        cmd.pt_row = row;
        ph_next    = ph + 1'b1;
        if (ph == PH_LAST) begin
          ph_next = '0;
          if (row == 2'd2) state_next = S_FIN;
          else row_next = row + 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          cmd.status = stat;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      top       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      top       <= top_next;
      out_valid <= cmd.out_ld || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    cnt  <= cnt_next;
    row  <= row_next;
    ph   <= ph_next;
    stat <= stat_next;
    if (accept) op_q <= op;
  end

endmodule

/* design/affine_matrix_stack_transform.sv */
// top level of the affine matrix stack engine
// One command is taken at a time; the result item sits in an output register so the
// next command is accepted while it waits. Matrix commands are paced by the single read
// and single write port of the matrix memory (twelve words read per matrix command and
// rewritten unless it transforms a point, one multiplier set per column), and rotations
// also by the iterative sine/cosine unit, which does the modulo-360 reduction and then
// 24 cordic steps. After reset level zero reads as the identity matrix with no clearing
// pass.
module affine_matrix_stack_transform (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          op,
  input  logic signed [31:0]  angle_deg,
  input  logic signed [31:0]  x_in,
  input  logic signed [31:0]  y_in,
  input  logic signed [31:0]  z_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  x_out,
  output logic signed [31:0]  y_out,
  output logic signed [31:0]  z_out,
  output logic [1:0]          status
);
  import amst_pkg::*;

  amst_cmd_t cmd;
  amst_sts_t sts;

  amst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  amst_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .op        (op),
    .angle_deg (angle_deg),
    .x_in      (x_in),
    .y_in      (y_in),
    .z_in      (z_in),
    .x_out     (x_out),
    .y_out     (y_out),
    .z_out     (z_out),
    .status    (status)
  );

endmodule

/* design/amst_checker.sv */
// port level checks for the affine matrix stack engine and their bind
module amst_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic signed [31:0]  x_out,
  input logic signed [31:0]  y_out,
  input logic signed [31:0]  z_out,
  input logic [1:0]          status
);
  import amst_pkg::*;

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // one item in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while busy");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("bad status code");

  // ignored push or pop carries no point
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> x_out == 0 && y_out == 0 && z_out == 0)
    else $error("nonzero point with error status");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind affine_matrix_stack_transform amst_checker u_amst_checker (.*);

/* sim/affine_matrix_stack_transform_test.sv */
// testbench for the affine matrix stack engine: directed and random command streams checked against a predictor
module affine_matrix_stack_transform_test;
  import amst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0] op;
    logic signed [31:0] ang;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [1:0] st;
  } res_t;

  localparam int WATCHDOG = 20000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [3:0] op;
  logic signed [31:0] angle_deg, x_in, y_in, z_in, x_out, y_out, z_out;
  logic [1:0] status;

  affine_matrix_stack_transform i_dut (.*);

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  int rx_gap = 0;
  bit pause_tx = 0;

  logic signed [31:0] mat_stack[STACK_DEPTH][MAT_WORDS];
  int unsigned cur_lvl;

  const longint atan_tab[CORDIC_STEPS] = '{
    754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115};

  function automatic longint fx_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic sine_cosine(input logic signed [31:0] a, output logic signed [31:0] sn,
                             output logic signed [31:0] cs);
    longint full, r, t, cx, cy, nx, half;
    bit flip;
    full = 64'sd360 <<< FRAC_BITS;
    half = 64'sd1 <<< (VEC_FRAC - FRAC_BITS - 1);
    r = longint'(a) % full;
    if (r < 0) r += full;
    r = r <<< (ANG_FRAC - FRAC_BITS);
    t = r;
    flip = 0;
    if (r > (64'sd270 <<< ANG_FRAC)) t = r - (64'sd360 <<< ANG_FRAC);
    else if (r > (64'sd90 <<< ANG_FRAC)) begin
      t = r - (64'sd180 <<< ANG_FRAC);
      flip = 1;
    end
    cx = CORDIC_GAIN;
    cy = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (t >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        t -= atan_tab[i];
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        t += atan_tab[i];
      end
      cx = nx;
    end
    cx = (cx + half) >>> (VEC_FRAC - FRAC_BITS);
    cy = (cy + half) >>> (VEC_FRAC - FRAC_BITS);
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    cs = cx[31:0];
    sn = cy[31:0];
  endtask

  task automatic post_mult(input logic signed [31:0] t[MAT_WORDS]);
    logic signed [31:0] r[MAT_WORDS];
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += fx_mul(mat_stack[cur_lvl][i*4+k], t[k*4+j]);
        if (j == 3) acc += mat_stack[cur_lvl][i*4+3];
        r[i*4+j] = clamp32(acc);
      end
    mat_stack[cur_lvl] = r;
  endtask

  task automatic set_identity(output logic signed [31:0] m[MAT_WORDS]);
    for (int i = 0; i < MAT_WORDS; i++) m[i] = 0;
    m[0] = Q_ONE;
    m[5] = Q_ONE;
    m[10] = Q_ONE;
  endtask

  task automatic predict_command(input cmd_t c);
    res_t r;
    logic signed [31:0] t[MAT_WORDS];
    logic signed [31:0] sn, cs;
    r = '0;
    set_identity(t);
    case (c.op)
      OP_IDENT: set_identity(mat_stack[cur_lvl]);
      OP_PUSH: begin
        if (cur_lvl == STACK_DEPTH - 1) r.st = ST_FULL;
        else begin
          mat_stack[cur_lvl + 1] = mat_stack[cur_lvl];
          cur_lvl++;
        end
      end
      OP_POP: begin
        if (cur_lvl == 0) r.st = ST_EMPTY;
        else cur_lvl--;
      end
      OP_ROTX, OP_ROTY, OP_ROTZ: begin
        sine_cosine(c.ang, sn, cs);
        if (c.op == OP_ROTX) begin
          t[5] = cs; t[6] = -sn; t[9] = sn; t[10] = cs;
        end else if (c.op == OP_ROTY) begin
          t[0] = cs; t[2] = sn; t[8] = -sn; t[10] = cs;
        end else begin
          t[0] = cs; t[1] = -sn; t[4] = sn; t[5] = cs;
        end
        post_mult(t);
      end
      OP_TRANS: begin
        t[3] = c.x; t[7] = c.y; t[11] = c.z;
        post_mult(t);
      end
      OP_SCALE: begin
        t[0] = c.x; t[5] = c.y; t[10] = c.z;
        post_mult(t);
      end
      OP_POINT: begin
        r.x = clamp32(fx_mul(mat_stack[cur_lvl][0], c.x) + fx_mul(mat_stack[cur_lvl][1], c.y)
                      + fx_mul(mat_stack[cur_lvl][2], c.z) + mat_stack[cur_lvl][3]);
        r.y = clamp32(fx_mul(mat_stack[cur_lvl][4], c.x) + fx_mul(mat_stack[cur_lvl][5], c.y)
                      + fx_mul(mat_stack[cur_lvl][6], c.z) + mat_stack[cur_lvl][7]);
        r.z = clamp32(fx_mul(mat_stack[cur_lvl][8], c.x) + fx_mul(mat_stack[cur_lvl][9], c.y)
                      + fx_mul(mat_stack[cur_lvl][10], c.z) + mat_stack[cur_lvl][11]);
      end
      default: ;
    endcase
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000 + Q_ONE / 2;
    endcase
  endfunction

  function automatic cmd_t make_cmd(input logic [3:0] o);
    cmd_t c;
    c.op = o;
    c.ang = ($urandom_range(0, 3) == 0) ? $urandom
            : $signed($urandom_range(0, 720 * 4)) * 32'sh4000 - 32'sh1680000;
    c.x = rand_word();
    c.y = rand_word();
    c.z = rand_word();
    return c;
  endfunction

  function automatic logic [3:0] pick_op();
    int p;
    p = $urandom_range(0, 99);
    if (p < 2) return 4'($urandom_range(9, 15));
    if (p < 6) return OP_IDENT;
    if (p < 14) return OP_PUSH;
    if (p < 22) return OP_POP;
    if (p < 40) return 4'($urandom_range(OP_ROTX, OP_ROTZ));
    if (p < 52) return OP_TRANS;
    if (p < 62) return OP_SCALE;
    return OP_POINT;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  int tx_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      tx_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_command('{op, angle_deg, x_in, y_in, z_in});
        void'(pending_cmds.pop_front());
      end
      if (in_valid && in_stall) begin
      end else if (tx_gap > 0) begin
        in_valid <= 0;
        tx_gap <= tx_gap - 1;
      end else if (pending_cmds.size() > 0 && !pause_tx) begin
        in_valid <= 1;
        op <= pending_cmds[0].op;
        angle_deg <= pending_cmds[0].ang;
        x_in <= pending_cmds[0].x;
        y_in <= pending_cmds[0].y;
        z_in <= pending_cmds[0].z;
        tx_gap <= rand_gap();
      end else in_valid <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      rx_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result item", x_out, 32'd0);
        end else begin
          res_t e;
          e = expected_results.pop_front();
          if (x_out !== e.x) report_mismatch("x_out", x_out, e.x);
          if (y_out !== e.y) report_mismatch("y_out", y_out, e.y);
          if (z_out !== e.z) report_mismatch("z_out", z_out, e.z);
          if (status !== e.st) report_mismatch("status", 32'(status), 32'(e.st));
        end
      end
      if (hold_off > 0) begin
        out_stall <= 1;
        hold_off <= hold_off - 1;
      end else if (rx_gap > 0) begin
        out_stall <= 1;
        rx_gap <= rx_gap - 1;
      end else begin
        out_stall <= 0;
        rx_gap <= rand_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [3:0] o;
    cur_lvl = 0;
    set_identity(mat_stack[0]);
    in_valid = 0;
    out_stall = 0;
    op = 0;
    angle_deg = 0;
    x_in = 0;
    y_in = 0;
    z_in = 0;
    rst = 1;
    repeat (12) @(posedge clk);
    rst <= 0;

    // directed: empty pop, extremes, rotations at quadrant edges, full stack
    pending_cmds.push_back('{OP_POP, 0, 0, 0, 0});
    pending_cmds.push_back('{OP_POINT, 0, 32'sh7fffffff, 32'sh80000000, -1});
    pending_cmds.push_back('{OP_SCALE, 0, 32'sh7fffffff, 32'sh80000000, Q_ONE});
    pending_cmds.push_back('{OP_POINT, 0, 32'sh7fffffff, 32'sh80000000, -1});
    pending_cmds.push_back('{OP_TRANS, 0, 32'sh7fffffff, 32'sh80000000, 5});
    pending_cmds.push_back('{OP_IDENT, 0, 0, 0, 0});
    pending_cmds.push_back('{OP_ROTX, 90 <<< 16, 0, 0, 0});
    pending_cmds.push_back('{OP_ROTY, 32'sh80000000, 0, 0, 0});
    pending_cmds.push_back('{OP_ROTZ, 32'sh7fffffff, 0, 0, 0});
    pending_cmds.push_back('{OP_ROTZ, -(270 <<< 16), 0, 0, 0});
    pending_cmds.push_back('{OP_POINT, 0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE});
    pending_cmds.push_back('{4'd15, -1, -1, -1, -1});
    for (int i = 0; i < STACK_DEPTH; i++) pending_cmds.push_back('{OP_PUSH, 0, 0, 0, 0});
    wait (pending_cmds.size() == 0);
    pause_tx = 1;
    wait (expected_results.size() == 0);
    pause_tx = 0;

    for (int n = 0; n < 1800; n++) begin
      o = pick_op();
      pending_cmds.push_back(make_cmd(o));
      if (n == 600) begin
        wait (pending_cmds.size() == 0);
        hold_off = 400;
      end
      if (n == 1200) begin
        wait (pending_cmds.size() == 0);
        pause_tx = 1;
        wait (expected_results.size() == 0);
        pause_tx = 0;
      end
      if (pending_cmds.size() > 50) wait (pending_cmds.size() < 20);
    end
    wait (pending_cmds.size() == 0 && expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
